[rtl/lct_pkg.sv]
// lct_pkg: shared types and constants for the lfu cache table
// used by lct_cell and lfu_cache_table; no dependencies
`default_nettype none

package lct_pkg;

   localparam int KEY_W       = 31;
   localparam int CAP_W       = 5;
   localparam int MAX_COUNT_W = 32;
   localparam int MAX_IDX_W   = 6;
   localparam int MAX_USED_W  = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP
   } state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT
   } upd_op_type;

   // broadcast to every cell at the end of a transaction
   typedef struct packed {
      upd_op_type             op;
      logic [MAX_IDX_W-1:0]   sel_idx;
      logic [MAX_IDX_W-1:0]   sel_rank;
      logic                   write_en;
      logic                   evict_vld;
      logic [MAX_IDX_W-1:0]   evict_idx;
      logic [KEY_W-1:0]       key;
      logic [KEY_W-1:0]       value;
   } update_type;

   // running victim / occupancy / free-slot search handed along the row
   typedef struct packed {
      logic                   best_vld;
      logic [MAX_COUNT_W-1:0] best_count;
      logic [MAX_IDX_W-1:0]   best_rank;
      logic [MAX_IDX_W-1:0]   best_idx;
      logic [KEY_W-1:0]       best_key;
      logic [MAX_USED_W-1:0]  used;
      logic                   free_vld;
      logic [MAX_IDX_W-1:0]   free_idx;
   } chain_type;

   typedef struct packed {
      logic                   valid;
      logic                   match;
      logic [KEY_W-1:0]       value;
      logic [MAX_IDX_W-1:0]   rank;
   } cell_status_type;

endpackage

`default_nettype wire

[rtl/lct_cell.sv]
// lct_cell: one cache entry with key match, update logic and one stage of the victim search
// depends on lct_pkg
`default_nettype none

module lct_cell #(
   parameter int COUNT_BITS = 16,
   parameter int RANK_W     = 4,
   parameter int INDEX      = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [lct_pkg::KEY_W-1:0]     lookup_key,
   input  lct_pkg::update_type          upd,
   input  lct_pkg::chain_type           chain_prev,
   output lct_pkg::chain_type           chain_out,
   output lct_pkg::cell_status_type     status
);
   import lct_pkg::*;

   localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(INDEX);

   logic                  valid_ff, valid_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KEY_W-1:0]      value_ff, value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   chain_type             chain_ff, chain_in;

   logic [MAX_COUNT_W-1:0] count_x;
   logic [MAX_IDX_W-1:0]   rank_x;

   assign count_x = MAX_COUNT_W'(count_ff);
   assign rank_x  = MAX_IDX_W'(rank_ff);

   // search stage
   always_comb begin
      chain_in      = chain_prev;
      chain_in.used = chain_prev.used + MAX_USED_W'(valid_ff);
      if (valid_ff) begin
         if (!chain_prev.best_vld || (count_x < chain_prev.best_count) ||
             ((count_x == chain_prev.best_count) && (rank_x > chain_prev.best_rank))) begin
            chain_in.best_vld   = 1'b1;
            chain_in.best_count = count_x;
            chain_in.best_rank  = rank_x;
            chain_in.best_idx   = MY_IDX;
            chain_in.best_key   = key_ff;
         end
      end else if (!chain_prev.free_vld) begin
         chain_in.free_vld = 1'b1;
         chain_in.free_idx = MY_IDX;
      end
   end

   // entry update
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      unique case (upd.op)
         UPD_TOUCH: begin
            if (upd.sel_idx == MY_IDX) begin
               rank_in = '0;
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
               if (upd.write_en) begin
                  value_in = upd.value;
               end
            end else if (valid_ff && (rank_x < upd.sel_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         UPD_INSERT: begin
            if (upd.sel_idx == MY_IDX) begin
               valid_in = 1'b1;
               key_in   = upd.key;
               value_in = upd.value;
               count_in = COUNT_BITS'(1);
               rank_in  = '0;
            end else if (upd.evict_vld && (upd.evict_idx == MY_IDX)) begin
               valid_in = 1'b0;
            end else if (valid_ff && (!upd.evict_vld || (rank_x < upd.sel_rank))) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         UPD_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         chain_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

   assign chain_out    = chain_ff;
   assign status.valid = valid_ff;
   assign status.match = valid_ff && (key_ff == lookup_key);
   assign status.value = value_ff;
   assign status.rank  = rank_x;

endmodule

`default_nettype wire

[rtl/lfu_cache_table.sv]
// lfu_cache_table: top level, control sequencer, response register and row of entry cells
// depends on lct_pkg and lct_cell
`default_nettype none

// Key/value cache of ENTRIES entries with least-frequently-used replacement, ties going to
// the least recently touched entry. One transaction is handled at a time. For a get, a put to a
// present key and any put while the capacity register is zero, the key is matched against all
// cells in parallel in the cycle after accept, and the result is registered from that match. A
// put of a new key then runs the victim search, which moves one cell down the row each cycle,
// and is registered at the end of the sweep. The next request is accepted as soon as the result is in the response
// register; a result that is not taken stalls the following one at its last cycle.
// csr_data sets the number of entries in use (values above ENTRIES act as ENTRIES).
module lfu_cache_table #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_cmd,
   input  wire [lct_pkg::KEY_W-1:0]     req_lookup_key,
   input  wire [lct_pkg::KEY_W-1:0]     req_write_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_hit,
   output logic [lct_pkg::KEY_W-1:0]    rsp_read_value,
   output logic                         rsp_evicted,
   output logic [lct_pkg::KEY_W-1:0]    rsp_evicted_key,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [lct_pkg::CAP_W-1:0]     csr_data
);
   import lct_pkg::*;

   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SWEEP_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(ENTRIES - 1);

   state_type             state_ff, state_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  cmd_ff;
   logic [KEY_W-1:0]      key_ff, value_ff;
   logic [SWEEP_W-1:0]    sweep_ff, sweep_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [KEY_W-1:0]      rsp_read_ff, rsp_read_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_W-1:0]      rsp_evkey_ff, rsp_evkey_in;

   chain_type             chain_link [ENTRIES+1];
   cell_status_type       cell_st [ENTRIES];
   update_type            upd;
   chain_type             chain_end;

   logic [ENTRIES-1:0]    match_vec, valid_vec;
   logic                  hit_any;
   logic [KEY_W-1:0]      hit_value;
   logic [MAX_IDX_W-1:0]  hit_idx, hit_rank;

   logic out_free, done, cap_zero, full, insert_path, sweep_last;
   logic evict, do_insert;
   logic [MAX_IDX_W-1:0]  slot;

   assign chain_link[0] = '0;
   assign chain_end     = chain_link[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lct_cell #(
         .COUNT_BITS (COUNT_BITS),
         .RANK_W     (RANK_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .lookup_key (key_ff),
         .upd        (upd),
         .chain_prev (chain_link[i]),
         .chain_out  (chain_link[i+1]),
         .status     (cell_st[i])
      );
      assign match_vec[i] = cell_st[i].match;
      assign valid_vec[i] = cell_st[i].valid;
   end

   // one-hot select of the matching entry
   always_comb begin
      hit_value = '0;
      hit_idx   = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_st[i].match) begin
            hit_value = hit_value | cell_st[i].value;
            hit_idx   = hit_idx | MAX_IDX_W'(i);
            hit_rank  = hit_rank | cell_st[i].rank;
         end
      end
   end

   assign hit_any     = |match_vec;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cap_zero    = (cap_ff == '0);
   assign full        = (chain_end.used >= MAX_USED_W'(cap_ff)) ||
                        (chain_end.used >= MAX_USED_W'(ENTRIES));
   assign insert_path = (cmd_ff == CMD_PUT) && !hit_any && !cap_zero;
   assign sweep_last  = (sweep_ff == SWEEP_LAST);
   assign evict       = full && chain_end.best_vld;
   assign do_insert   = evict || chain_end.free_vld;
   assign slot        = (chain_end.free_vld && (!evict || (chain_end.free_idx < chain_end.best_idx)))
                        ? chain_end.free_idx : chain_end.best_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (insert_path) begin
               state_in = ST_SWEEP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_last && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready      = 1'b0;
      done           = 1'b0;
      sweep_in       = sweep_ff;
      upd            = '0;
      upd.op         = UPD_NONE;
      upd.key        = key_ff;
      upd.value      = value_ff;
      rsp_hit_in     = 1'b0;
      rsp_read_in    = '0;
      rsp_evicted_in = 1'b0;
      rsp_evkey_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset && !csr_valid;
         end
         ST_LOOKUP: begin
            sweep_in = '0;
            if (!insert_path && out_free) begin
               done = 1'b1;
               if (hit_any && ((cmd_ff == CMD_GET) || !cap_zero)) begin
                  upd.op       = UPD_TOUCH;
                  upd.sel_idx  = hit_idx;
                  upd.sel_rank = hit_rank;
                  upd.write_en = (cmd_ff == CMD_PUT);
                  rsp_hit_in   = 1'b1;
                  if (cmd_ff == CMD_GET) begin
                     rsp_read_in = hit_value;
                  end
               end
            end
         end
         ST_SWEEP: begin
            if (!sweep_last) begin
               sweep_in = sweep_ff + 1'b1;
            end else if (out_free) begin
               done           = 1'b1;
               rsp_evicted_in = evict;
               if (evict) begin
                  rsp_evkey_in = chain_end.best_key;
               end
               if (do_insert) begin
                  upd.op        = UPD_INSERT;
                  upd.sel_idx   = slot;
                  upd.sel_rank  = chain_end.best_rank;
                  upd.evict_vld = evict;
                  upd.evict_idx = chain_end.best_idx;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // capacity writes only between transactions
   assign csr_ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_lookup_key;
         value_ff <= req_write_value;
      end
      if (done) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_read_ff    <= rsp_read_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_evkey_ff   <= rsp_evkey_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

   // keys in the table are unique
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one entry matches the key");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported together with a hit");

   a_used_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && sweep_last) |->
         (chain_end.used == MAX_USED_W'($countones(valid_vec))))
      else $error("occupancy from the search chain disagrees with the valid bits");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && sweep_last) |-> (chain_end.free_vld == (valid_vec != '1)))
      else $error("free slot search disagrees with the valid bits");

endmodule

`default_nettype wire
